// ===== hw/rtl/scpe_pkg.sv =====
// shared types, byte codes and reply table of the serial command packet engine
`timescale 1ns / 1ps

package scpe_pkg;

    // framing and reply bytes
    localparam logic [7:0] START_BYTE  = 8'h2E;
    localparam logic [7:0] REPLY_CONF  = 8'hB0;
    localparam logic [7:0] LED_ON_ST   = 8'hF1;
    localparam logic [7:0] LED_OFF_ST  = 8'hF0;
    localparam logic [7:0] TAIL_FIRST  = 8'h0A;
    localparam logic [7:0] TAIL_SECOND = 8'h0B;
    localparam logic [7:0] FW_REV_BYTE = 8'h08;

    // header layout and fixed overhead of a packet
    localparam int HDR_CONF    = 1;
    localparam int HDR_CODE    = 2;
    localparam int HDR_LEN_HI  = 3;
    localparam int HDR_LEN_LO  = 4;
    localparam int CMD_LED_NUM = 5;
    localparam int CMD_ACTION  = 6;
    localparam int CMD_ARG_HI  = 7;
    localparam int CMD_ARG_LO  = 8;
    localparam int PKT_EXTRA   = 7;
    localparam logic [7:0] LED_NUM_BASE = 8'd3;

    // command codes
    localparam logic [7:0] CODE_ECHO = 8'h00;
    localparam logic [7:0] CODE_FW   = 8'h01;
    localparam logic [7:0] CODE_LED  = 8'h02;

    // led actions and set values
    localparam logic [7:0] ACT_GET   = 8'h00;
    localparam logic [7:0] ACT_SET   = 8'h01;
    localparam logic [7:0] ACT_BLINK = 8'h02;
    localparam logic [7:0] SET_OFF    = 8'h00;
    localparam logic [7:0] SET_ON     = 8'h01;
    localparam logic [7:0] SET_TOGGLE = 8'h02;

    // input item kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // job kinds handed from receiver to transmitter
    localparam logic [1:0] JOB_STATUS = 2'd0;
    localparam logic [1:0] JOB_ECHO   = 2'd1;
    localparam logic [1:0] JOB_FW     = 2'd2;
    localparam logic [1:0] JOB_GET    = 2'd3;

    // index of the final byte of each fixed reply
    localparam logic [3:0] FW_LAST  = 4'd8;
    localparam logic [3:0] GET_LAST = 4'd9;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] idx;
        logic       on;
        logic [7:0] led;
    } t_job;

    // byte i of the firmware or led-get reply
    function automatic logic [7:0] reply_byte(input logic [1:0] kind, input logic [3:0] i,
                                              input logic [7:0] idx, input logic on);
        logic       fw;
        logic [7:0] st;
        fw = (kind == JOB_FW);
        st = on ? LED_ON_ST : LED_OFF_ST;
        case (i)
            4'd0:    reply_byte = START_BYTE;
            4'd1:    reply_byte = REPLY_CONF;
            4'd2:    reply_byte = fw ? CODE_FW : CODE_LED;
            4'd3:    reply_byte = 8'h00;
            4'd4:    reply_byte = fw ? 8'h02 : 8'h03;
            4'd5:    reply_byte = fw ? 8'h00 : idx;
            4'd6:    reply_byte = fw ? FW_REV_BYTE : 8'h00;
            4'd7:    reply_byte = fw ? TAIL_FIRST : st;
            4'd8:    reply_byte = fw ? TAIL_SECOND : TAIL_FIRST;
            4'd9:    reply_byte = TAIL_SECOND;
            default: reply_byte = 8'h00;
        endcase
    endfunction

endpackage

// ===== hw/rtl/scpe_store.sv =====
// packet byte store: one write port, one registered read port
`timescale 1ns / 1ps

module scpe_store #(
    parameter int BUF_DEPTH = 64,
    parameter int ADDR_W    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered, updated while i_re is high
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/scpe_rx.sv =====
// receive framing, command decode, led and blink state
`timescale 1ns / 1ps

module scpe_rx #(
    parameter int BUF_DEPTH = 64,
    parameter int ADDR_W    = 6,
    parameter int POS_W     = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_req_type,
    input  logic [7:0]         i_rx_byte,
    output logic               o_we,
    output logic [ADDR_W-1:0]  o_waddr,
    output logic [7:0]         o_wdata,
    output scpe_pkg::t_job     o_job,
    output logic [POS_W-1:0]   o_len
);

    import scpe_pkg::*;

    localparam logic [15:0] MAX_PLEN = 16'(BUF_DEPTH - PKT_EXTRA);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_len, n_len;
    logic [7:0]       r_conf, n_conf;
    logic [7:0]       r_code, n_code;
    logic [7:0]       r_len_hi, n_len_hi;
    logic [7:0]       r_b5, n_b5;
    logic [7:0]       r_b6, n_b6;
    logic [7:0]       r_b7, n_b7;
    logic [7:0]       r_b8, n_b8;
    logic [7:0]       r_led, n_led;
    logic             r_blink, n_blink;
    logic [2:0]       r_bidx, n_bidx;
    logic [14:0]      r_half, n_half;
    logic [14:0]      r_tick, n_tick;

    logic [14:0]      tick_inc;
    logic [15:0]      plen;
    logic [POS_W-1:0] pos_inc;
    logic [7:0]       e6, e7, e8;
    logic [7:0]       led_idx;
    logic             idx_ok;
    logic [7:0]       led_mask;
    logic [15:0]      speed;
    logic             is_req;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len    <= '0;
            r_led    <= '0;
            r_blink  <= 1'b0;
            r_bidx   <= '0;
            r_half   <= '0;
            r_tick   <= '0;
        end else begin
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_led    <= n_led;
            r_blink  <= n_blink;
            r_bidx   <= n_bidx;
            r_half   <= n_half;
            r_tick   <= n_tick;
        end
    end

    // captured header and command bytes
    always_ff @(posedge i_clk) begin
        r_conf   <= n_conf;
        r_code   <= n_code;
        r_len_hi <= n_len_hi;
        r_b5     <= n_b5;
        r_b6     <= n_b6;
        r_b7     <= n_b7;
        r_b8     <= n_b8;
    end

    // command arguments, with the byte arriving now taking the place of its register
    assign e6       = (r_pos == POS_W'(CMD_ACTION)) ? i_rx_byte : r_b6;
    assign e7       = (r_pos == POS_W'(CMD_ARG_HI)) ? i_rx_byte : r_b7;
    assign e8       = (r_pos == POS_W'(CMD_ARG_LO)) ? i_rx_byte : r_b8;
    assign led_idx  = r_b5 - LED_NUM_BASE;
    assign idx_ok   = (led_idx < 8'd8);
    assign led_mask = idx_ok ? (8'd1 << led_idx[2:0]) : 8'd0;
    assign speed    = {e7, e8};
    assign is_req   = r_conf[6] && !r_conf[7] && !r_conf[5];
    assign tick_inc = r_tick + 15'd1;
    assign plen     = {r_len_hi, i_rx_byte};
    assign pos_inc  = r_pos + POS_W'(1);

    // next state and job for the accepted item
    always_comb begin
        n_pos     = r_pos;
        n_len     = r_len;
        n_conf    = r_conf;
        n_code    = r_code;
        n_len_hi  = r_len_hi;
        n_b5      = r_b5;
        n_b6      = r_b6;
        n_b7      = r_b7;
        n_b8      = r_b8;
        n_led     = r_led;
        n_blink   = r_blink;
        n_bidx    = r_bidx;
        n_half    = r_half;
        n_tick    = r_tick;
        o_we      = 1'b0;
        o_waddr   = r_pos[ADDR_W-1:0];
        o_wdata   = i_rx_byte;
        o_job.kind = JOB_STATUS;
        o_job.idx  = led_idx;
        o_job.on   = |(r_led & led_mask);

        if (i_accept) begin
            if (i_req_type == REQ_TICK) begin
                // blink timer
                if (r_blink) begin
                    if (tick_inc >= r_half) begin
                        n_tick = '0;
                        n_led  = r_led ^ (8'd1 << r_bidx);
                    end else begin
                        n_tick = tick_inc;
                    end
                end
            end else if (r_pos == '0) begin
                // hunt for start byte
                if (i_rx_byte == START_BYTE) begin
                    o_we  = 1'b1;
                    n_pos = POS_W'(1);
                    n_b7  = 8'h00;
                    n_b8  = 8'h00;
                end
            end else begin
                o_we  = 1'b1;
                n_pos = pos_inc;
                // capture the bytes the decoder needs
                if (r_pos == POS_W'(HDR_CONF))    n_conf   = i_rx_byte;
                if (r_pos == POS_W'(HDR_CODE))    n_code   = i_rx_byte;
                if (r_pos == POS_W'(HDR_LEN_HI))  n_len_hi = i_rx_byte;
                if (r_pos == POS_W'(CMD_LED_NUM)) n_b5     = i_rx_byte;
                if (r_pos == POS_W'(CMD_ACTION))  n_b6     = i_rx_byte;
                if (r_pos == POS_W'(CMD_ARG_HI))  n_b7     = i_rx_byte;
                if (r_pos == POS_W'(CMD_ARG_LO))  n_b8     = i_rx_byte;

                if (r_pos == POS_W'(HDR_LEN_LO)) begin
                    // length check, oversized packets are dropped
                    if (plen > MAX_PLEN) begin
                        n_pos = '0;
                    end else begin
                        n_len = plen[POS_W-1:0] + POS_W'(PKT_EXTRA);
                    end
                end else if (r_pos > POS_W'(HDR_LEN_LO) && pos_inc >= r_len) begin
                    // packet complete, decode
                    n_pos = '0;
                    if (is_req) begin
                        case (r_code)
                            CODE_ECHO: o_job.kind = JOB_ECHO;
                            CODE_FW:   o_job.kind = JOB_FW;
                            CODE_LED: begin
                                case (e6)
                                    ACT_GET: o_job.kind = JOB_GET;
                                    ACT_SET: begin
                                        if (e7 == SET_OFF)    n_led = r_led & ~led_mask;
                                        if (e7 == SET_ON)     n_led = r_led | led_mask;
                                        if (e7 == SET_TOGGLE) n_led = r_led ^ led_mask;
                                    end
                                    ACT_BLINK: begin
                                        if (idx_ok) begin
                                            n_half  = speed[15:1];
                                            n_bidx  = led_idx[2:0];
                                            n_blink = |speed[15:1];
                                            n_tick  = '0;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end
            end
        end
        o_job.led = n_led;
    end

    assign o_len = r_len;

endmodule

// ===== hw/rtl/scpe_tx.sv =====
// result sequencer: echo reads, fixed replies, status results, output register
`timescale 1ns / 1ps

module scpe_tx #(
    parameter int ADDR_W = 6,
    parameter int POS_W  = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  scpe_pkg::t_job    i_job,
    input  logic [POS_W-1:0]  i_len,
    output logic              o_idle,
    output logic              o_re,
    output logic [ADDR_W-1:0] o_raddr,
    input  logic [7:0]        i_rdata,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_tx_valid,
    output logic [7:0]        o_tx_byte,
    output logic              o_last,
    output logic [7:0]        o_led
);

    import scpe_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ECHO_RD = 3'd1;
    localparam logic [2:0] S_ECHO_WR = 3'd2;
    localparam logic [2:0] S_REPLY   = 3'd3;
    localparam logic [2:0] S_STATUS  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [POS_W-1:0] r_cnt, n_cnt;
    t_job             r_job, n_job;
    logic [POS_W-1:0] r_len, n_len;
    logic             r_valid, n_valid;
    logic             r_tx_valid, n_tx_valid;
    logic [7:0]       r_tx_byte, n_tx_byte;
    logic             r_last, n_last;
    logic [7:0]       r_led, n_led;

    logic             slot_free;
    logic             load;
    logic [POS_W-1:0] cnt_inc;
    logic             reply_end;

    assign slot_free = !r_valid || i_ready;
    assign cnt_inc   = r_cnt + POS_W'(1);
    assign reply_end = (r_job.kind == JOB_FW) ? (r_cnt[3:0] == FW_LAST)
                                              : (r_cnt[3:0] == GET_LAST);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // job and output payload registers
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_job      <= n_job;
        r_len      <= n_len;
        r_tx_valid <= n_tx_valid;
        r_tx_byte  <= n_tx_byte;
        r_last     <= n_last;
        r_led      <= n_led;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_job      = r_job;
        n_len      = r_len;
        n_tx_valid = r_tx_valid;
        n_tx_byte  = r_tx_byte;
        n_last     = r_last;
        n_led      = r_led;
        load       = 1'b0;
        o_re       = 1'b0;
        o_raddr    = r_cnt[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_job = i_job;
                    n_len = i_len;
                    n_cnt = '0;
                    case (i_job.kind)
                        JOB_ECHO:   n_state = S_ECHO_RD;
                        JOB_FW:     n_state = S_REPLY;
                        JOB_GET:    n_state = S_REPLY;
                        default:    n_state = S_STATUS;
                    endcase
                end
            end
            S_ECHO_RD: begin
                o_re    = 1'b1;
                n_state = S_ECHO_WR;
            end
            S_ECHO_WR: begin
                if (slot_free) begin
                    load       = 1'b1;
                    n_tx_valid = 1'b1;
                    n_tx_byte  = i_rdata;
                    n_last     = (cnt_inc == r_len);
                    n_led      = r_job.led;
                    n_cnt      = cnt_inc;
                    n_state    = (cnt_inc == r_len) ? S_IDLE : S_ECHO_RD;
                end
            end
            S_REPLY: begin
                if (slot_free) begin
                    load       = 1'b1;
                    n_tx_valid = 1'b1;
                    n_tx_byte  = reply_byte(r_job.kind, r_cnt[3:0], r_job.idx, r_job.on);
                    n_last     = reply_end;
                    n_led      = r_job.led;
                    n_cnt      = cnt_inc;
                    n_state    = reply_end ? S_IDLE : S_REPLY;
                end
            end
            S_STATUS: begin
                if (slot_free) begin
                    load       = 1'b1;
                    n_tx_valid = 1'b0;
                    n_tx_byte  = 8'h00;
                    n_last     = 1'b1;
                    n_led      = r_job.led;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // output register occupancy
        if (load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    assign o_idle     = (r_state == S_IDLE);
    assign o_valid    = r_valid;
    assign o_tx_valid = r_tx_valid;
    assign o_tx_byte  = r_tx_byte;
    assign o_last     = r_last;
    assign o_led      = r_led;

endmodule

// ===== hw/rtl/serial_command_packet_engine_top.sv =====
// top level of the serial command packet engine
`timescale 1ns / 1ps

// Serial command packet engine. Input items are received serial bytes or
// millisecond ticks (tuser = 1); each item yields one or more result items on
// the master side, the final one marked by tlast. An item that gives no reply
// loads one status result (tuser = 0) carrying the led bits. The byte that
// completes a packet triggers its command: an echo reads the packet back from
// the packet store byte by byte, a store read and then a load of the output
// register for each byte; firmware and led-get replies stream out at one byte
// a cycle while the receiver holds tready high, and tready low stalls any
// result. The input side is ready whenever the result sequencer is idle, also
// while the last result still sits in the output register. The packet store
// needs no clearing after reset.
module serial_command_packet_engine_top #(
    parameter int BUF_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tuser,   // [0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] tx_byte, [15:8] led_state
    output logic        o_m_tuser,   // [0] tx_valid
    output logic        o_m_tlast    // last
);

    import scpe_pkg::*;

    localparam int ADDR_W = $clog2(BUF_DEPTH);
    localparam int POS_W  = $clog2(BUF_DEPTH + 1);

    logic              accept;
    logic              tx_idle;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rdata;
    t_job              job;
    logic [POS_W-1:0]  len;
    logic [7:0]        tx_byte;
    logic [7:0]        led;

    assign o_s_tready = tx_idle;
    assign accept     = i_s_tvalid && tx_idle;

    // framing and command decode
    scpe_rx #(
        .BUF_DEPTH (BUF_DEPTH),
        .ADDR_W    (ADDR_W),
        .POS_W     (POS_W)
    ) u_rx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_s_tuser),
        .i_rx_byte  (i_s_tdata),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_job      (job),
        .o_len      (len)
    );

    // packet store
    scpe_store #(
        .BUF_DEPTH (BUF_DEPTH),
        .ADDR_W    (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // result sequencer
    scpe_tx #(
        .ADDR_W (ADDR_W),
        .POS_W  (POS_W)
    ) u_tx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_job      (job),
        .i_len      (len),
        .o_idle     (tx_idle),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_tx_valid (o_m_tuser),
        .o_tx_byte  (tx_byte),
        .o_last     (o_m_tlast),
        .o_led      (led)
    );

    assign o_m_tdata = {led, tx_byte};

endmodule

// ===== tb/serial_command_packet_engine_top_tb.sv =====
// self-checking testbench for the serial command packet engine
`timescale 1ns / 1ps

module serial_command_packet_engine_top_tb;

    import scpe_pkg::*;

    localparam int BUF_DEPTH = 64;

    // conf byte bits and the plain request conf
    localparam int CONF_DIR_BIT = 5;
    localparam int CONF_REQ_BIT = 6;
    localparam int CONF_RSP_BIT = 7;
    localparam logic [7:0] REQ_CONF = 8'h40;

    // low length bytes of the fixed replies
    localparam logic [7:0] FW_LEN_LO  = 8'h02;
    localparam logic [7:0] GET_LEN_LO = 8'h03;

    // one result item as the block should send it
    typedef struct {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic [7:0] led;
    } t_tx_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;   // [7:0] rx_byte
    logic        i_s_tuser = 1'b0;    // [0] req_type
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;           // [7:0] tx_byte, [15:8] led_state
    logic        o_m_tuser;           // [0] tx_valid
    logic        o_m_tlast;           // last

    // predicted engine state
    logic [6:0]  rx_pos = '0;
    logic [15:0] pay_len = '0;
    logic [7:0]  pkt_mem [0:BUF_DEPTH-1];
    logic [7:0]  led_bits = '0;
    logic        blink_on = 1'b0;
    logic [2:0]  blink_led = '0;
    logic [14:0] half_period = '0;
    logic [14:0] tick_cnt = '0;

    logic [7:0]  reply_bytes [$];
    t_tx_item    tx_items_due [$];

    int fail_count = 0;
    int items_sent = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    serial_command_packet_engine_top #(
        .BUF_DEPTH(BUF_DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser),
        .o_m_tlast(o_m_tlast)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("serial_command_packet_engine_top: mismatch");
        $finish;
    end

    // packet byte as the command logic sees it, zero past the packet end
    function automatic logic [7:0] stored_byte(input int i);
        if (i < int'(pay_len) + PKT_EXTRA && i < BUF_DEPTH)
            return pkt_mem[i];
        return 8'h00;
    endfunction

    function automatic void run_led_command();
        logic [7:0]  idx;
        logic [7:0]  act;
        logic        ok;
        logic [15:0] speed;
        idx = stored_byte(CMD_LED_NUM) - LED_NUM_BASE;
        act = stored_byte(CMD_ACTION);
        ok = (idx < 8'd8);
        case (act)
            ACT_GET: begin
                reply_bytes.push_back(START_BYTE);
                reply_bytes.push_back(REPLY_CONF);
                reply_bytes.push_back(CODE_LED);
                reply_bytes.push_back(8'h00);
                reply_bytes.push_back(GET_LEN_LO);
                reply_bytes.push_back(idx);
                reply_bytes.push_back(8'h00);
                reply_bytes.push_back((ok && led_bits[idx[2:0]]) ? LED_ON_ST : LED_OFF_ST);
                reply_bytes.push_back(TAIL_FIRST);
                reply_bytes.push_back(TAIL_SECOND);
            end
            ACT_SET: begin
                if (ok) begin
                    case (stored_byte(CMD_ARG_HI))
                        SET_OFF:    led_bits[idx[2:0]] = 1'b0;
                        SET_ON:     led_bits[idx[2:0]] = 1'b1;
                        SET_TOGGLE: led_bits[idx[2:0]] = ~led_bits[idx[2:0]];
                        default:    ;
                    endcase
                end
            end
            ACT_BLINK: begin
                if (ok) begin
                    speed = {stored_byte(CMD_ARG_HI), stored_byte(CMD_ARG_LO)};
                    half_period = speed[15:1];
                    blink_led = idx[2:0];
                    blink_on = (speed[15:1] != '0);
                    tick_cnt = '0;
                end
            end
            default: ;
        endcase
    endfunction

    // act on a finished packet if it is a request from the host
    function automatic void run_command();
        logic [7:0] conf;
        logic [7:0] code;
        conf = stored_byte(HDR_CONF);
        code = stored_byte(HDR_CODE);
        if (!conf[CONF_REQ_BIT] || conf[CONF_RSP_BIT] || conf[CONF_DIR_BIT])
            return;
        case (code)
            CODE_ECHO: begin
                for (int i = 0; i < int'(pay_len) + PKT_EXTRA && i < BUF_DEPTH; i++)
                    reply_bytes.push_back(stored_byte(i));
            end
            CODE_FW: begin
                reply_bytes.push_back(START_BYTE);
                reply_bytes.push_back(REPLY_CONF);
                reply_bytes.push_back(CODE_FW);
                reply_bytes.push_back(8'h00);
                reply_bytes.push_back(FW_LEN_LO);
                reply_bytes.push_back(8'h00);
                reply_bytes.push_back(FW_REV_BYTE);
                reply_bytes.push_back(TAIL_FIRST);
                reply_bytes.push_back(TAIL_SECOND);
            end
            CODE_LED: run_led_command();
            default: ;
        endcase
    endfunction

    // packet framing of one received byte
    function automatic void take_byte(input logic [7:0] b);
        int pos;
        pos = int'(rx_pos);
        if (pos == 0) begin
            if (b == START_BYTE) begin
                pkt_mem[0] = b;
                rx_pos = 7'd1;
            end
            return;
        end
        if (pos < BUF_DEPTH)
            pkt_mem[pos] = b;
        if (pos <= HDR_LEN_LO) begin
            rx_pos = 7'(pos + 1);
            if (int'(rx_pos) == HDR_LEN_LO + 1) begin
                pay_len = {pkt_mem[HDR_LEN_HI], pkt_mem[HDR_LEN_LO]};
                if (int'(pay_len) > BUF_DEPTH - PKT_EXTRA)
                    rx_pos = '0;
            end
            return;
        end
        rx_pos = 7'(pos + 1);
        if (int'(rx_pos) >= int'(pay_len) + PKT_EXTRA) begin
            rx_pos = '0;
            run_command();
        end
    endfunction

    // expected result items of one accepted input item
    function automatic void predict_item(input logic kind, input logic [7:0] b);
        t_tx_item it;
        reply_bytes.delete();
        if (kind == REQ_TICK) begin
            if (blink_on) begin
                tick_cnt = tick_cnt + 15'd1;
                if (tick_cnt >= half_period) begin
                    tick_cnt = '0;
                    led_bits[blink_led] = ~led_bits[blink_led];
                end
            end
        end else begin
            take_byte(b);
        end
        if (reply_bytes.size() == 0) begin
            it = '{tx_valid: 1'b0, tx_byte: 8'h00, last: 1'b1, led: led_bits};
            tx_items_due.push_back(it);
        end else begin
            foreach (reply_bytes[i]) begin
                it = '{tx_valid: 1'b1, tx_byte: reply_bytes[i],
                       last: (i == reply_bytes.size() - 1), led: led_bits};
                tx_items_due.push_back(it);
            end
        end
    endfunction

    function automatic void check_tx_item();
        t_tx_item want;
        if (tx_items_due.size() == 0) begin
            $error("result item with nothing expected: tdata %h tuser %b tlast %b",
                   o_m_tdata, o_m_tuser, o_m_tlast);
            fail_count++;
            return;
        end
        want = tx_items_due.pop_front();
        if (o_m_tuser !== want.tx_valid) begin
            $error("tx_valid: expected %0d, got %0d", want.tx_valid, o_m_tuser);
            fail_count++;
        end
        if (o_m_tdata[7:0] !== want.tx_byte) begin
            $error("tx_byte: expected %h, got %h", want.tx_byte, o_m_tdata[7:0]);
            fail_count++;
        end
        if (o_m_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, o_m_tlast);
            fail_count++;
        end
        if (o_m_tdata[15:8] !== want.led) begin
            $error("led_state: expected %h, got %h", want.led, o_m_tdata[15:8]);
            fail_count++;
        end
    endfunction

    // both handshakes sampled at the edge: predict first, then check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                predict_item(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready)
                check_tx_item();
        end
    end

    // receiver stalls
    always @(posedge i_clk)
        i_m_tready <= ($urandom_range(99) >= snk_stall_pct);

    // one input item, with random idle cycles ahead of it
    task automatic send_item(input logic kind, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= kind;
        i_s_tdata <= b;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    // hold the sender until every expected item has come back
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tx_items_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(REQ_TICK, 8'($urandom));
    endtask

    task automatic send_header(input logic [7:0] conf, input logic [7:0] code,
                               input logic [15:0] len);
        send_item(REQ_BYTE, START_BYTE);
        send_item(REQ_BYTE, conf);
        send_item(REQ_BYTE, code);
        send_item(REQ_BYTE, len[15:8]);
        send_item(REQ_BYTE, len[7:0]);
    endtask

    // full packet with two random check bytes
    task automatic send_packet(input logic [7:0] conf, input logic [7:0] code,
                               input logic [7:0] body [$]);
        send_header(conf, code, 16'(body.size()));
        foreach (body[i])
            send_item(REQ_BYTE, body[i]);
        repeat (2) send_item(REQ_BYTE, 8'($urandom));
    endtask

    task automatic send_led_cmd(input logic [7:0] conf, input logic [7:0] num,
                                input logic [7:0] act, input logic [7:0] hi,
                                input logic [7:0] lo, input int body_len);
        logic [7:0] body [$];
        logic [7:0] args [4];
        args = '{num, act, hi, lo};
        for (int i = 0; i < body_len && i < 4; i++)
            body.push_back(args[i]);
        send_packet(conf, CODE_LED, body);
    endtask

    task automatic send_echo(input logic [7:0] conf, input int len, input bit patterned);
        logic [7:0] body [$];
        for (int i = 0; i < len; i++)
            body.push_back(patterned ? (i[0] ? 8'hFF : 8'hA5) : 8'($urandom));
        send_packet(conf, CODE_ECHO, body);
    endtask

    function automatic logic [7:0] request_conf();
        logic [7:0] conf;
        conf = 8'($urandom);
        conf[CONF_RSP_BIT] = 1'b0;
        conf[CONF_REQ_BIT] = 1'b1;
        conf[CONF_DIR_BIT] = 1'b0;
        return conf;
    endfunction

    // ticks and stray bytes while idle only give status items
    task automatic test_idle_traffic();
        send_ticks(2);
        send_item(REQ_BYTE, 8'h00);
        send_item(REQ_BYTE, 8'hFF);
        wait_drained();
    endtask

    // shortest and longest echo, the long one under receiver stalls
    task automatic test_echo_extremes();
        send_echo(REQ_CONF, 0, 1'b0);
        snk_stall_pct = 85;
        send_echo(8'h5F, BUF_DEPTH - PKT_EXTRA, 1'b1);
        wait_drained();
        snk_stall_pct = 0;
    endtask

    task automatic test_firmware_reply();
        logic [7:0] body [$];
        send_packet(REQ_CONF, CODE_FW, body);
        wait_drained();
    endtask

    task automatic test_led_commands();
        send_led_cmd(REQ_CONF, LED_NUM_BASE, ACT_SET, SET_ON, 8'h00, 3);
        send_led_cmd(REQ_CONF, LED_NUM_BASE + 8'd7, ACT_SET, SET_ON, 8'h00, 3);
        send_led_cmd(REQ_CONF, LED_NUM_BASE, ACT_SET, SET_TOGGLE, 8'h00, 3);
        send_led_cmd(REQ_CONF, LED_NUM_BASE, ACT_GET, 8'h00, 8'h00, 2);
        send_led_cmd(REQ_CONF, LED_NUM_BASE + 8'd7, ACT_GET, 8'h00, 8'h00, 2);
        send_led_cmd(REQ_CONF, LED_NUM_BASE + 8'd7, ACT_SET, SET_OFF, 8'h00, 3);
        // unknown set value and unknown action
        send_led_cmd(REQ_CONF, LED_NUM_BASE + 8'd1, ACT_SET, 8'h03, 8'h00, 3);
        send_led_cmd(REQ_CONF, LED_NUM_BASE + 8'd1, 8'h03, SET_ON, 8'h00, 3);
        // led index out of range, above and below the base
        send_led_cmd(REQ_CONF, LED_NUM_BASE + 8'd8, ACT_SET, SET_ON, 8'h00, 3);
        send_led_cmd(REQ_CONF, LED_NUM_BASE - 8'd1, ACT_GET, 8'h00, 8'h00, 2);
        send_led_cmd(REQ_CONF, LED_NUM_BASE + 8'd8, ACT_BLINK, 8'h00, 8'h04, 4);
        // zero-length get: led number and action ride in the check bytes
        send_header(REQ_CONF, CODE_LED, 16'd0);
        send_item(REQ_BYTE, LED_NUM_BASE + 8'd1);
        send_item(REQ_BYTE, ACT_GET);
        wait_drained();
    endtask

    task automatic test_rejected_packets();
        logic [7:0] body [$];
        send_packet(8'hC0, CODE_FW, body);
        send_packet(8'h00, CODE_FW, body);
        send_packet(8'h60, CODE_FW, body);
        send_packet(8'hFF, CODE_ECHO, body);
        send_packet(REQ_CONF, 8'h03, body);
        // oversized length drops the packet at the header
        send_header(REQ_CONF, CODE_ECHO, 16'(BUF_DEPTH - PKT_EXTRA + 1));
        send_item(REQ_BYTE, 8'h11);
        send_header(REQ_CONF, CODE_FW, 16'hFFFF);
        send_item(REQ_BYTE, 8'h22);
        wait_drained();
    endtask

    task automatic test_blink_timing();
        send_led_cmd(REQ_CONF, LED_NUM_BASE + 8'd1, ACT_BLINK, 8'h00, 8'h04, 4);
        send_ticks(7);
        // speed of one halves to zero and stops blinking
        send_led_cmd(REQ_CONF, LED_NUM_BASE + 8'd1, ACT_BLINK, 8'h00, 8'h01, 4);
        send_ticks(3);
        send_led_cmd(REQ_CONF, LED_NUM_BASE + 8'd7, ACT_BLINK, 8'hFF, 8'hFF, 4);
        send_ticks(3);
        send_led_cmd(REQ_CONF, LED_NUM_BASE + 8'd2, ACT_BLINK, 8'h00, 8'h03, 4);
        send_ticks(4);
        // short blink packet: speed bytes lie past the end and read as zero
        send_header(REQ_CONF, CODE_LED, 16'd0);
        send_item(REQ_BYTE, LED_NUM_BASE + 8'd2);
        send_item(REQ_BYTE, ACT_BLINK);
        send_ticks(3);
        wait_drained();
    endtask

    // mostly well-formed packets with random content, some noise and broken framing
    task automatic random_traffic(input int n_items);
        int         start_count;
        logic [7:0] num;
        logic [7:0] act;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] b;
        logic [7:0] body [$];
        start_count = items_sent;
        while (items_sent - start_count < n_items) begin
            body.delete();
            case ($urandom_range(9))
                0, 1, 2: begin
                    num = ($urandom_range(7) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(2, 11));
                    act = ($urandom_range(9) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(2));
                    if (act == ACT_BLINK) begin
                        hi = ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00;
                        lo = 8'($urandom_range(12));
                    end else begin
                        hi = ($urandom_range(7) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(2));
                        lo = 8'($urandom);
                    end
                    send_led_cmd(($urandom_range(7) == 0) ? 8'($urandom) : request_conf(),
                                 num, act, hi, lo,
                                 ($urandom_range(3) == 0) ? $urandom_range(4) : 4);
                end
                3: send_ticks($urandom_range(1, 12));
                4: send_echo(request_conf(),
                             ($urandom_range(7) == 0) ? $urandom_range(BUF_DEPTH - PKT_EXTRA)
                                                      : $urandom_range(10), 1'b0);
                5: begin
                    repeat ($urandom_range(3)) body.push_back(8'($urandom));
                    send_packet(request_conf(), CODE_FW, body);
                end
                6: begin
                    repeat ($urandom_range(4)) body.push_back(8'($urandom));
                    send_packet(8'($urandom), 8'($urandom_range(3)), body);
                end
                7: begin
                    repeat ($urandom_range(1, 4)) begin
                        b = 8'($urandom);
                        send_item(REQ_BYTE, (b == START_BYTE) ? 8'h00 : b);
                    end
                end
                8: begin
                    if ($urandom_range(1)) begin
                        send_header(request_conf(), 8'($urandom_range(2)),
                                    16'($urandom_range(BUF_DEPTH - PKT_EXTRA + 1, 65535)));
                    end else begin
                        // truncated header, the following traffic fills it up
                        send_item(REQ_BYTE, START_BYTE);
                        repeat ($urandom_range(1, 3)) send_item(REQ_BYTE, 8'($urandom));
                    end
                end
                default: send_led_cmd(request_conf(), 8'($urandom_range(3, 10)), ACT_GET,
                                      8'($urandom), 8'($urandom), 2);
            endcase
        end
    endtask

    // random traffic under each idling pattern, drained between phases
    task automatic test_random_traffic();
        int src_pct [4];
        int snk_pct [4];
        src_pct = '{0, 85, 0, 29};
        snk_pct = '{0, 0, 85, 29};
        for (int p = 0; p < 4; p++) begin
            src_idle_pct = src_pct[p];
            snk_stall_pct = snk_pct[p];
            random_traffic(2);
            wait_drained();
        end
        src_idle_pct = 0;
        snk_stall_pct = 0;
    endtask

    initial begin
        for (int i = 0; i < BUF_DEPTH; i++)
            pkt_mem[i] = 8'h00;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_traffic();
        test_echo_extremes();
        test_firmware_reply();
        test_led_commands();
        test_rejected_packets();
        test_blink_timing();
        test_random_traffic();
        wait_drained();
        // room for any stray item after the last expected one
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("serial_command_packet_engine_top: match");
        else
            $display("serial_command_packet_engine_top: mismatch");
        $finish;
    end

endmodule
